// ===== src/pprg_pkg.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN guard package
// Shared types, field widths, operation codes and register map.
// ----------------------------------------------------------------------------
package pprg_pkg;

  localparam int PinW    = 14;
  localparam int PeriodW = 16;
  localparam int HoldW   = 8;
  localparam int FailW   = 8;
  localparam int AgeW    = 9;
  localparam int OpW     = 2;

  localparam int InDataW  = 48;
  localparam int OutDataW = 48;
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 4;

  // Operation codes carried in the input tuser.
  localparam logic [OpW-1:0] OP_TICK     = 2'd0;
  localparam logic [OpW-1:0] OP_VERIFY   = 2'd1;
  localparam logic [OpW-1:0] OP_SNAPSHOT = 2'd2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROTATE_PERIOD = 2'd0;
  localparam logic [1:0] REG_PAIRED_HOLD   = 2'd1;
  localparam logic [1:0] REG_MAX_FAILS     = 2'd2;

  localparam logic [PeriodW-1:0] ROTATE_PERIOD_RST = 16'd300;
  localparam logic [HoldW-1:0]   PAIRED_HOLD_RST   = 8'd5;
  localparam logic [FailW-1:0]   MAX_FAILS_RST     = 8'd5;

  localparam logic [PeriodW-1:0] OVERDUE_MAX = '1;
  localparam logic [FailW-1:0]   FAIL_MAX    = '1;
  localparam logic [AgeW-1:0]    AGE_MAX     = '1;

  typedef struct packed {
    logic [PeriodW-1:0] rotate_period;
    logic [HoldW-1:0]   paired_hold;
    logic [FailW-1:0]   max_fails;
  } cfg_t;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic [PinW-1:0] pin_value;
    logic            pin_well_formed;
    logic [PinW-1:0] fresh_pin_rotate;
    logic [PinW-1:0] fresh_pin_reset;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [PinW-1:0]    current_pin;
    logic               current_valid;
    logic [PinW-1:0]    previous_pin;
    logic               previous_valid;
    logic [PeriodW-1:0] seconds_remaining;
    logic               paired_shown;
  } result_t;

endpackage

// ===== src/pprg_cfg.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN guard configuration registers
// APB-style register file holding period, paired hold time and fail limit.
// ----------------------------------------------------------------------------
module pprg_cfg
  import pprg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_period <= ROTATE_PERIOD_RST;
      cfg_r.paired_hold   <= PAIRED_HOLD_RST;
      cfg_r.max_fails     <= MAX_FAILS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ROTATE_PERIOD: cfg_r.rotate_period <= pwdata[PeriodW-1:0];
        REG_PAIRED_HOLD:   cfg_r.paired_hold   <= pwdata[HoldW-1:0];
        REG_MAX_FAILS:     cfg_r.max_fails     <= pwdata[FailW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROTATE_PERIOD: prdata = {{(CfgDataW-PeriodW){1'b0}}, cfg_r.rotate_period};
      REG_PAIRED_HOLD:   prdata = {{(CfgDataW-HoldW){1'b0}}, cfg_r.paired_hold};
      REG_MAX_FAILS:     prdata = {{(CfgDataW-FailW){1'b0}}, cfg_r.max_fails};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/pprg_engine.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN guard engine
// Holds the PIN state and computes one item's state update and result.
// ----------------------------------------------------------------------------
module pprg_engine
  import pprg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [PinW-1:0]    cur_r,    cur_nxt;
  logic               curp_r,   curp_nxt;
  logic [PinW-1:0]    prior_r,  prior_nxt;
  logic               priorp_r, priorp_nxt;
  logic [PeriodW-1:0] cd_r,     cd_nxt;
  logic [PeriodW-1:0] od_r,     od_nxt;
  logic [FailW-1:0]   fail_r,   fail_nxt;
  logic               paired_r, paired_nxt;
  logic [AgeW-1:0]    age_r,    age_nxt;

  logic [FailW-1:0] fail_inc;
  logic             hit;
  logic             accepted;

  always_comb begin
    cur_nxt    = cur_r;
    curp_nxt   = curp_r;
    prior_nxt  = prior_r;
    priorp_nxt = priorp_r;
    cd_nxt     = cd_r;
    od_nxt     = od_r;
    fail_nxt   = fail_r;
    paired_nxt = paired_r;
    age_nxt    = age_r;
    fail_inc   = '0;
    hit        = 1'b0;
    accepted   = 1'b0;

    if (item.operation == OP_TICK) begin
      if (curp_r) begin
        if (cd_r != '0) begin
          cd_nxt = cd_r - 1'b1;
        end else if (od_r != OVERDUE_MAX) begin
          od_nxt = od_r + 1'b1;
        end
      end
      if (paired_r && age_r != AGE_MAX) begin
        age_nxt = age_r + 1'b1;
      end
    end else begin
      // Rotation or first setup happens before any guess is checked.
      if (!curp_r || cd_r == '0) begin
        if (curp_r && od_r < cfg.rotate_period) begin
          prior_nxt  = cur_r;
          priorp_nxt = 1'b1;
        end else begin
          prior_nxt  = '0;
          priorp_nxt = 1'b0;
        end
        cur_nxt  = item.fresh_pin_rotate;
        curp_nxt = 1'b1;
        cd_nxt   = cfg.rotate_period;
        od_nxt   = '0;
        fail_nxt = '0;
      end

      if (item.operation == OP_VERIFY) begin
        hit = item.pin_well_formed &&
              ((curp_nxt && item.pin_value == cur_nxt) ||
               (priorp_nxt && item.pin_value == prior_nxt));
        fail_inc = (fail_nxt == FAIL_MAX) ? fail_nxt : fail_nxt + 1'b1;
        if (hit || fail_inc >= cfg.max_fails) begin
          cur_nxt    = item.fresh_pin_reset;
          curp_nxt   = 1'b1;
          prior_nxt  = '0;
          priorp_nxt = 1'b0;
          cd_nxt     = cfg.rotate_period;
          od_nxt     = '0;
          fail_nxt   = '0;
        end else begin
          fail_nxt = fail_inc;
        end
        if (hit) begin
          paired_nxt = 1'b1;
          age_nxt    = '0;
          accepted   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.accepted          = accepted;
    result.current_pin       = curp_nxt ? cur_nxt : '0;
    result.current_valid     = curp_nxt;
    result.previous_pin      = priorp_nxt ? prior_nxt : '0;
    result.previous_valid    = priorp_nxt;
    result.seconds_remaining = cd_nxt;
    result.paired_shown      = paired_nxt && (age_nxt <= {1'b0, cfg.paired_hold});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      curp_r   <= 1'b0;
      prior_r  <= '0;
      priorp_r <= 1'b0;
      cd_r     <= '0;
      od_r     <= '0;
      fail_r   <= '0;
      paired_r <= 1'b0;
      age_r    <= '0;
    end else if (item_fire) begin
      cur_r    <= cur_nxt;
      curp_r   <= curp_nxt;
      prior_r  <= prior_nxt;
      priorp_r <= priorp_nxt;
      cd_r     <= cd_nxt;
      od_r     <= od_nxt;
      fail_r   <= fail_nxt;
      paired_r <= paired_nxt;
      age_r    <= age_nxt;
    end
  end

`ifndef SYNTHESIS
  // A previous PIN only exists alongside a current one.
  a_prior_needs_current: assert property (@(posedge clk) disable iff (!rst_n)
    priorp_r |-> curp_r)
    else $error("previous PIN valid without a current PIN");

  // Overdue time only accumulates once the countdown has run out.
  a_overdue_after_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (od_r != '0) |-> (cd_r == '0))
    else $error("overdue counter nonzero while countdown still running");

  // A successful verify leaves a fresh pairing and a cleared fail count.
  a_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && accepted) |=> (paired_r && age_r == '0 && fail_r == '0 && !priorp_r))
    else $error("state after a match is not a fresh pairing");

  // Any verify or snapshot leaves a current PIN in place.
  a_current_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.operation != OP_TICK) |=> curp_r)
    else $error("no current PIN after a verify or snapshot");
`endif

endmodule

// ===== src/pairing_pin_rotation_guard_unit.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN rotation guard
// Rotating pairing PIN with previous-PIN grace, lockout and paired indication.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the in_ channel is one item: a one-second tick,
// a verify request or a snapshot query, selected by in_tuser. in_tdata
// carries the guess and two fresh random PINs supplied by the host. For
// every input transaction exactly one result transaction leaves on the out_
// channel with the PIN state after that item.
// The item is captured in an input register when it is accepted, the state
// update and result are computed in one pass, and the result is captured
// in the output register, where out_tvalid rises, once that register is
// free. Throughput is one item per cycle while out_tready stays high; the
// state update loop in the engine sets that figure, and in_tready stays high
// while the output register is empty or being drained.
// When the receiver holds out_tready low, the result waits in the output
// register, one more item waits in the input register, and then in_tready
// drops until the result is taken. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears both pipeline stages and all PIN
// state, and loads the configuration registers with their defaults (period
// 300 s, paired hold 5 s, five failures). The user writes configuration via
// cfg_ APB only with no transaction in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module pairing_pin_rotation_guard_unit
  import pprg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_tvalid,
  output logic                in_tready,
  // [13:0] pin_value, [14] pin_well_formed, [28:15] fresh_pin_rotate,
  // [42:29] fresh_pin_reset, [47:43] zero fill
  input  logic [InDataW-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OpW-1:0]      in_tuser,

  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] accepted, [14:1] current_pin, [15] current_valid, [29:16] previous_pin,
  // [30] previous_valid, [46:31] seconds_remaining, [47] paired_shown
  output logic [OutDataW-1:0] out_tdata,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0] cfg_prdata,
  output logic                cfg_pready
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item_r;
  logic    in_valid_r;
  result_t result;
  result_t out_r;
  logic    out_valid_r;
  logic    out_free;
  logic    item_fire;

  // Unpack the input transaction into its fields.
  assign in_item.operation        = in_tuser;
  assign in_item.pin_value        = in_tdata[13:0];
  assign in_item.pin_well_formed  = in_tdata[14];
  assign in_item.fresh_pin_rotate = in_tdata[28:15];
  assign in_item.fresh_pin_reset  = in_tdata[42:29];

  // The output register can take a new result when empty or being read.
  assign out_free  = !out_valid_r || out_tready;
  assign item_fire = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  pprg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pprg_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (item_r),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.paired_shown, out_r.seconds_remaining, out_r.previous_valid,
                       out_r.previous_pin, out_r.current_valid, out_r.current_pin,
                       out_r.accepted};

endmodule

// ===== tb/pprg_guard_checker.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN guard checker
// Watches the input, result and register ports of the guard. Every input
// transaction is run through a cycle-free model of the PIN state, and the
// result it predicts is compared field by field with the next result
// transaction. Register reads are compared with the last value written.
// ----------------------------------------------------------------------------
module pprg_guard_checker
  import pprg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [OpW-1:0]      in_tuser,

  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,

  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [CfgDataW-1:0] cfg_pwdata,
  input  logic [CfgDataW-1:0] cfg_prdata,
  input  logic                cfg_pready,

  output int                  mismatches,
  output int                  in_flight
);

  // Register copy and PIN state as the guard should hold them.
  cfg_t               settings;
  logic [PinW-1:0]    cur_pin;
  logic               cur_ok;
  logic [PinW-1:0]    prev_pin;
  logic               prev_ok;
  logic [PeriodW-1:0] countdown;
  logic [PeriodW-1:0] overdue;
  logic [FailW-1:0]   misses;
  logic               paired;
  logic [AgeW-1:0]    age;

  result_t expected_results[$];
  item_t   seen_item;
  result_t seen_result;
  result_t want;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Fresh PIN with no previous one; used for first setup, matches and lockout.
  function automatic void reissue(input logic [PinW-1:0] fresh);
    cur_pin   = fresh;
    cur_ok    = 1'b1;
    prev_pin  = '0;
    prev_ok   = 1'b0;
    countdown = settings.rotate_period;
    overdue   = '0;
    misses    = '0;
  endfunction

  function automatic void rotate_when_due(input logic [PinW-1:0] fresh);
    if (!cur_ok) begin
      reissue(fresh);
    end else if (countdown == '0) begin
      // The outgoing PIN keeps working only if rotation is less than a period late.
      if (overdue < settings.rotate_period) begin
        prev_pin = cur_pin;
        prev_ok  = 1'b1;
      end else begin
        prev_pin = '0;
        prev_ok  = 1'b0;
      end
      cur_pin   = fresh;
      countdown = settings.rotate_period;
      overdue   = '0;
      misses    = '0;
    end
  endfunction

  function automatic result_t guard_step(input item_t it);
    result_t r;
    logic    hit;
    r.accepted = 1'b0;
    case (it.operation)
      OP_TICK: begin
        if (cur_ok) begin
          if (countdown != '0) begin
            countdown = countdown - 1'b1;
          end else if (overdue != OVERDUE_MAX) begin
            overdue = overdue + 1'b1;
          end
        end
        if (paired && age != AGE_MAX) begin
          age = age + 1'b1;
        end
      end
      OP_VERIFY: begin
        rotate_when_due(it.fresh_pin_rotate);
        hit = it.pin_well_formed &&
              ((cur_ok && it.pin_value == cur_pin) || (prev_ok && it.pin_value == prev_pin));
        if (hit) begin
          reissue(it.fresh_pin_reset);
          paired     = 1'b1;
          age        = '0;
          r.accepted = 1'b1;
        end else begin
          if (misses != FAIL_MAX) begin
            misses = misses + 1'b1;
          end
          if (misses >= settings.max_fails) begin
            reissue(it.fresh_pin_reset);
          end
        end
      end
      // Snapshot, and the spare code, which behaves as a snapshot.
      default: begin
        rotate_when_due(it.fresh_pin_rotate);
      end
    endcase
    r.current_pin       = cur_ok ? cur_pin : '0;
    r.current_valid     = cur_ok;
    r.previous_pin      = prev_ok ? prev_pin : '0;
    r.previous_valid    = prev_ok;
    r.seconds_remaining = countdown;
    r.paired_shown      = paired && (age <= {1'b0, settings.paired_hold});
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.rotate_period = ROTATE_PERIOD_RST;
      settings.paired_hold   = PAIRED_HOLD_RST;
      settings.max_fails     = MAX_FAILS_RST;
      cur_pin   = '0;
      cur_ok    = 1'b0;
      prev_pin  = '0;
      prev_ok   = 1'b0;
      countdown = '0;
      overdue   = '0;
      misses    = '0;
      paired    = 1'b0;
      age       = '0;
      expected_results.delete();
      in_flight <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_ROTATE_PERIOD: settings.rotate_period = cfg_pwdata[PeriodW-1:0];
            REG_PAIRED_HOLD:   settings.paired_hold   = cfg_pwdata[HoldW-1:0];
            REG_MAX_FAILS:     settings.max_fails     = cfg_pwdata[FailW-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[3:2])
            REG_ROTATE_PERIOD: check_field("rotate_period read",
                                           32'(settings.rotate_period), cfg_prdata);
            REG_PAIRED_HOLD:   check_field("paired_hold read",
                                           32'(settings.paired_hold), cfg_prdata);
            REG_MAX_FAILS:     check_field("max_fails read",
                                           32'(settings.max_fails), cfg_prdata);
            default: ;
          endcase
        end
      end

      if (out_tvalid && out_tready) begin
        seen_result.accepted          = out_tdata[0];
        seen_result.current_pin       = out_tdata[14:1];
        seen_result.current_valid     = out_tdata[15];
        seen_result.previous_pin      = out_tdata[29:16];
        seen_result.previous_valid    = out_tdata[30];
        seen_result.seconds_remaining = out_tdata[46:31];
        seen_result.paired_shown      = out_tdata[47];
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with none expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(seen_result.accepted));
          check_field("current_pin", 32'(want.current_pin),
                      32'(seen_result.current_pin));
          check_field("current_valid", 32'(want.current_valid),
                      32'(seen_result.current_valid));
          check_field("previous_pin", 32'(want.previous_pin),
                      32'(seen_result.previous_pin));
          check_field("previous_valid", 32'(want.previous_valid),
                      32'(seen_result.previous_valid));
          check_field("seconds_remaining", 32'(want.seconds_remaining),
                      32'(seen_result.seconds_remaining));
          check_field("paired_shown", 32'(want.paired_shown),
                      32'(seen_result.paired_shown));
        end
      end

      if (in_tvalid && in_tready) begin
        seen_item.operation        = in_tuser;
        seen_item.pin_value        = in_tdata[13:0];
        seen_item.pin_well_formed  = in_tdata[14];
        seen_item.fresh_pin_rotate = in_tdata[28:15];
        seen_item.fresh_pin_reset  = in_tdata[42:29];
        expected_results.push_back(guard_step(seen_item));
      end

      in_flight <= expected_results.size();
    end
  end

endmodule

// ===== tb/tb_pairing_pin_rotation_guard_unit.sv =====
// ----------------------------------------------------------------------------
// Pairing PIN rotation guard testbench
// Drives ticks, verify requests and snapshot queries into the guard under a
// series of register settings and idle patterns, and leaves all prediction
// and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_pairing_pin_rotation_guard_unit
  import pprg_pkg::*;
();

  // The spare operation code. The guard treats it as a snapshot query.
  localparam logic [OpW-1:0] OP_RESERVED = 2'd3;

  // Length of the deliberate result back-pressure window, in cycles.
  localparam int LONG_HOLD_CYCLES = 48;
  // Cycles without any accepted transaction before the run is declared hung.
  // Random stalls and the hold-off window stay far below this.
  localparam int QUIET_LIMIT = 2000;
  // Extra cycles after the drain to catch stray results.
  localparam int DRAIN_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n;

  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [OpW-1:0]      in_tuser;

  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;

  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  int mismatches;
  int in_flight;

  // Per-phase idle rates, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit hold_req = 1'b0;

  // The last few fresh PINs handed to the guard. Guesses drawn from here hit
  // the current or previous PIN often enough to exercise matches.
  logic [PinW-1:0] recent_pins [4];
  logic [1:0]      recent_wr = '0;

  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pairing_pin_rotation_guard_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pprg_guard_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .in_flight   (in_flight)
  );

  // Result side. Each cycle out_tready is redrawn from the current stall
  // rate. On request it is held low for a fixed window, counted here, while
  // the sender keeps offering transactions so that both pipeline stages fill
  // and in_tready drops.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detection: any cycle with an accepted transaction on either channel
  // restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction accepted for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it is accepted. in_tvalid
  // is left high, so items can follow back to back; the next call
  // or a drain decides whether it drops.
  task automatic send_item(input logic [OpW-1:0] op, input logic [PinW-1:0] guess,
                           input logic formed, input logic [PinW-1:0] fresh_rot,
                           input logic [PinW-1:0] fresh_rst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, fresh_rst, fresh_rot, formed, guess};
    recent_pins[recent_wr]        = fresh_rot;
    recent_pins[recent_wr + 2'd1] = fresh_rst;
    recent_wr = recent_wr + 2'd2;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly in-range PINs, with an occasional value beyond four digits, which
  // the guard must store unchanged.
  function automatic logic [PinW-1:0] random_fresh();
    return ($urandom_range(19) == 0) ? PinW'($urandom_range(16383))
                                     : PinW'($urandom_range(9999));
  endfunction

  task automatic send_random_item();
    int              pick;
    logic [OpW-1:0]  op;
    logic [PinW-1:0] guess;
    pick = $urandom_range(99);
    if (pick < 45) begin
      op = OP_TICK;
    end else if (pick < 83) begin
      op = OP_VERIFY;
    end else if (pick < 97) begin
      op = OP_SNAPSHOT;
    end else begin
      op = OP_RESERVED;
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      guess = recent_pins[2'($urandom_range(3))];
    end else if (pick < 90) begin
      guess = PinW'($urandom_range(9999));
    end else begin
      guess = PinW'($urandom_range(16383));
    end
    send_item(op, guess, $urandom_range(9) != 0, random_fresh(), random_fresh());
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // One register transaction: setup cycle, then access cycle until pready.
  // The trailing idle cycle keeps psel from being lowered and raised in the
  // same step when accesses follow each other.
  task automatic cfg_access(input logic write, input logic [1:0] idx,
                            input logic [CfgDataW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the guard empty. Each write is read back; the
  // checker compares the read data with what it recorded.
  task automatic set_config(input logic [PeriodW-1:0] period, input logic [HoldW-1:0] hold,
                            input logic [FailW-1:0] fails);
    drain();
    cfg_access(1'b1, REG_ROTATE_PERIOD, CfgDataW'(period));
    cfg_access(1'b0, REG_ROTATE_PERIOD, '0);
    cfg_access(1'b1, REG_PAIRED_HOLD, CfgDataW'(hold));
    cfg_access(1'b0, REG_PAIRED_HOLD, '0);
    cfg_access(1'b1, REG_MAX_FAILS, CfgDataW'(fails));
    cfg_access(1'b0, REG_MAX_FAILS, '0);
  endtask

  task automatic run_phase(input logic [PeriodW-1:0] period, input logic [HoldW-1:0] hold,
                           input logic [FailW-1:0] fails, input int idle_pct,
                           input int stall_pct, input int count, input bit long_hold);
    set_config(period, hold, fails);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    repeat (count) send_random_item();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    foreach (recent_pins[i]) recent_pins[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values (300 s, 5 s, 5 fails).
    // A tick with no PIN yet changes nothing.
    send_item(OP_TICK, 14'd0, 1'b1, 14'd0, 14'd0);
    // A verify with no PIN first sets one up from the rotate PIN, then misses.
    send_item(OP_VERIFY, 14'd0, 1'b1, 14'd9999, 14'd5);
    // Right digits but not well formed: still a miss.
    send_item(OP_VERIFY, 14'd9999, 1'b0, 14'd0, 14'd0);
    // Match: the PIN is replaced by the reset PIN and pairing is shown.
    send_item(OP_VERIFY, 14'd9999, 1'b1, 14'd0, 14'd0);
    // Match on PIN zero; the new PIN is above four digits and kept as is.
    send_item(OP_VERIFY, 14'd0, 1'b1, 14'd16383, 14'd16383);
    // Spare operation code: a snapshot, no rotation yet.
    send_item(OP_RESERVED, 14'd0, 1'b0, 14'd123, 14'd0);
    send_item(OP_VERIFY, 14'd16383, 1'b1, 14'd0, 14'd4321);
    send_item(OP_TICK, 14'd0, 1'b0, 14'd0, 14'd0);

    // Short period, short hold and a three-miss lockout.
    set_config(16'd2, 8'd1, 8'd3);
    // Three misses lock out and reissue PIN 8888 with a fresh countdown.
    repeat (3) send_item(OP_VERIFY, 14'd1, 1'b1, 14'd0, 14'd8888);
    // Count down to zero, then one second overdue.
    repeat (3) send_item(OP_TICK, 14'd0, 1'b1, 14'd0, 14'd0);
    // Late by less than a period: 8888 survives as the previous PIN.
    send_item(OP_SNAPSHOT, 14'd0, 1'b1, 14'd1111, 14'd0);
    // A guess of the previous PIN is accepted.
    send_item(OP_VERIFY, 14'd8888, 1'b1, 14'd0, 14'd2222);
    // Paired indication for the hold time, then overdue by a full period.
    repeat (4) send_item(OP_TICK, 14'd0, 1'b1, 14'd0, 14'd0);
    // Late by a whole period: the previous PIN is dropped.
    send_item(OP_SNAPSHOT, 14'd0, 1'b1, 14'd3333, 14'd0);
    send_item(OP_VERIFY, 14'd3333, 1'b0, 14'd0, 14'd5);
    send_item(OP_VERIFY, 14'd0, 1'b1, 14'd0, 14'd5);
    send_item(OP_VERIFY, 14'd9999, 1'b1, 14'd0, 14'd0);

    // Random phases: register settings, sender idle %, receiver stall %.
    run_phase(16'd5, 8'd3, 8'd4, 0, 0, 180, 1'b0);
    run_phase(16'd1, 8'd0, 8'd1, 79, 0, 180, 1'b0);
    // Zero period rotates on every verify and snapshot; zero limit locks out
    // on every miss.
    run_phase(16'd0, 8'd0, 8'd0, 0, 79, 180, 1'b0);
    run_phase(16'hFFFF, 8'hFF, 8'hFF, 11, 11, 120, 1'b0);

    // A long run of ticks with no idling drives the paired age past the
    // longest hold and into saturation.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (520) send_item(OP_TICK, random_fresh(), 1'b1, random_fresh(), random_fresh());

    // Back-pressure phase: the result side holds off while items keep coming.
    run_phase(16'd3, 8'd2, 8'd2, 0, 0, 120, 1'b1);
    run_phase(ROTATE_PERIOD_RST, PAIRED_HOLD_RST, MAX_FAILS_RST, 30, 30, 120, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
